### rtl/core/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder package
// Beat types, code constants and the helpers that turn a code point into
// one or two UTF-16 code units.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  // Code point and unit constants
  localparam logic [31:0] SuppBase    = 32'h0001_0000;
  localparam logic [15:0] HiSurrBase  = 16'hD800;
  localparam logic [15:0] LoSurrBase  = 16'hDC00;
  localparam logic [1:0]  ContTag     = 2'b10;
  localparam int unsigned MaxUnits    = 4;
  localparam int unsigned QueueDepth  = 2;

  // One input beat: a raw byte of the text
  typedef struct packed {
    logic [7:0] byte_value;
    logic       is_last;
  } in_t;

  // One output beat: a UTF-16 code unit
  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
    logic [2:0]  bytes_used;
  } out_t;

  // The units of one character: a single unit or a surrogate pair
  typedef struct packed {
    out_t u0;
    out_t u1;
    logic pair;
  } char_units_t;

  // All units caused by one input byte
  typedef struct packed {
    out_t [MaxUnits-1:0] units;
    logic [2:0]          num;
  } bundle_t;

  // Split a code point into units; values at or above 0x10000 form a pair
  function automatic char_units_t emit_char(logic [31:0] cp, logic [2:0] used);
    char_units_t res;
    logic [31:0] r;
    r = cp - SuppBase;
    if (cp >= SuppBase) begin
      res.u0   = '{code_unit: HiSurrBase + r[25:10], last_unit: 1'b0, bytes_used: used};
      res.u1   = '{code_unit: LoSurrBase + {6'd0, r[9:0]}, last_unit: 1'b1,
                   bytes_used: used};
      res.pair = 1'b1;
    end else begin
      res.u0   = '{code_unit: cp[15:0], last_unit: 1'b1, bytes_used: used};
      res.u1   = '0;
      res.pair = 1'b0;
    end
    return res;
  endfunction

  // Sequence length of a lead byte: 2 plus the run of ones from bit 5 down
  function automatic logic [3:0] lead_len(logic [7:0] b);
    logic [3:0] len;
    logic       run;
    len = 4'd2;
    run = 1'b1;
    for (int i = 5; i >= 0; i--) begin
      run = run & b[i];
      len = len + {3'd0, run};
    end
    return len;
  endfunction

  // Lead payload: 0x7F shifted right by the length, shift capped at 6
  function automatic logic [31:0] lead_bits(logic [7:0] b, logic [3:0] len);
    logic [3:0] sh;
    logic [7:0] mask;
    sh   = (len > 4'd6) ? 4'd6 : len;
    mask = 8'h7F >> sh;
    return {24'd0, b & mask};
  endfunction

endpackage

### rtl/core/utf8_to_utf16_transcoder.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder
// Decodes a UTF-8 byte stream and emits UTF-16 code units, one per beat.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+--------------------------
//  in      | sink      | in_valid_i / in_stall_o   | in_data_i  (u8u16_pkg::in_t)
//  out     | source    | out_valid_o / out_stall_i | out_data_o (u8u16_pkg::out_t)
//
// A byte is decoded in the cycle it is taken; its units (0 to 3) land in a
// two-entry result queue and leave one per cycle. Throughput is one byte per
// cycle while each byte yields at most one unit; otherwise the output port sets
// the pace. Both hold while out_stall_i is low. in_stall_o rises only when both
// queue entries are full. Reset clears the decoder state and empties the queue.
module utf8_to_utf16_transcoder (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  u8u16_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output u8u16_pkg::out_t out_data_o
);

  // Decoder state
  logic [31:0] acc_q, acc_d;
  logic [2:0]  rem_q, rem_d;
  logic [2:0]  taken_q, taken_d;
  logic        pend_q, pend_d;

  // Result queue
  u8u16_pkg::bundle_t slot_q [u8u16_pkg::QueueDepth];
  u8u16_pkg::bundle_t slot_d [u8u16_pkg::QueueDepth];
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] idx_q, idx_d;

  logic                   in_fire, out_fire, pop, push;
  u8u16_pkg::bundle_t     bnd;
  u8u16_pkg::char_units_t flush_ch, new_ch;
  logic [31:0]            acc_c, lead_acc;
  logic [2:0]             taken_c, rem_c, n1;
  logic [3:0]             len;
  logic [7:0]             b;
  logic                   last, cont;

  assign in_fire  = in_valid_i && !in_stall_o;
  assign in_stall_o = (cnt_q == 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = slot_q[0].units[idx_q];
  assign out_fire    = out_valid_o && !out_stall_i;
  assign pop  = out_fire && ({1'b0, idx_q} == slot_q[0].num - 3'd1);
  assign push = in_fire && (bnd.num != 3'd0);

  assign b    = in_data_i.byte_value;
  assign last = in_data_i.is_last;
  assign cont = pend_q && (b[7:6] == u8u16_pkg::ContTag);

  // Decode one byte: next state and the units it releases
  always_comb begin
    acc_d    = acc_q;
    rem_d    = rem_q;
    taken_d  = taken_q;
    pend_d   = pend_q;
    bnd      = '0;
    acc_c    = {acc_q[25:0], b[5:0]};
    taken_c  = taken_q + 3'd1;
    rem_c    = rem_q - 3'd1;
    len      = u8u16_pkg::lead_len(b);
    lead_acc = u8u16_pkg::lead_bits(b, len);
    flush_ch = u8u16_pkg::emit_char(cont ? acc_c : acc_q, cont ? taken_c : taken_q);
    new_ch   = u8u16_pkg::emit_char((b < 8'h80) ? {24'd0, b} : lead_acc, 3'd1);
    n1       = 3'd0;

    if (cont) begin
      // Continuation: shift in six bits, close when full or at text end
      if (rem_c == 3'd0 || last) begin
        bnd.units[0] = flush_ch.u0;
        bnd.units[1] = flush_ch.u1;
        bnd.num      = flush_ch.pair ? 3'd2 : 3'd1;
        acc_d   = '0;
        rem_d   = '0;
        taken_d = '0;
        pend_d  = 1'b0;
      end else begin
        acc_d   = acc_c;
        rem_d   = rem_c;
        taken_d = taken_c;
      end
    end else begin
      // Close an open character early
      if (pend_q) begin
        bnd.units[0] = flush_ch.u0;
        bnd.units[1] = flush_ch.u1;
        n1 = flush_ch.pair ? 3'd2 : 3'd1;
      end
      acc_d   = '0;
      rem_d   = '0;
      taken_d = '0;
      pend_d  = 1'b0;
      if (b < 8'h80 || last) begin
        // Single byte, or a lead flushed by the end of text
        bnd.units[n1[1:0]] = new_ch.u0;
        if (new_ch.pair) begin
          bnd.units[n1[1:0] + 2'd1] = new_ch.u1;
        end
        bnd.num = n1 + (new_ch.pair ? 3'd2 : 3'd1);
      end else begin
        // Open a new character; length is capped at seven
        bnd.num = n1;
        acc_d   = lead_acc;
        taken_d = 3'd1;
        rem_d   = ((len > 4'd7) ? 3'd7 : len[2:0]) - 3'd1;
        pend_d  = 1'b1;
      end
    end
  end

  // Queue: drop the head when its last unit leaves, append new bundles
  always_comb begin
    slot_d = slot_q;
    cnt_d  = cnt_q;
    idx_d  = idx_q;
    if (out_fire) begin
      idx_d = pop ? 2'd0 : idx_q + 2'd1;
    end
    if (pop) begin
      slot_d[0] = slot_q[1];
      cnt_d     = cnt_q - 2'd1;
    end
    if (push) begin
      slot_d[cnt_d[0]] = bnd;
      cnt_d            = cnt_d + 2'd1;
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      rem_q   <= '0;
      taken_q <= '0;
      pend_q  <= 1'b0;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else begin
      if (in_fire) begin
        acc_q   <= acc_d;
        rem_q   <= rem_d;
        taken_q <= taken_d;
        pend_q  <= pend_d;
      end
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  // Hold queue payload
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

### sim/utf8_to_utf16_checker.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder checker
// Watches both channels, decodes every accepted byte with its own copy of the
// decoder state and compares each accepted code unit with the oldest one due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_to_utf16_checker
  import u8u16_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_stall_i,
  input  in_t  in_data_i,
  input  logic out_valid_i,
  input  logic out_stall_i,
  input  out_t out_data_i,
  output int   fail_cnt_o,
  output int   units_due_o,
  output int   bytes_seen_o,
  output int   units_seen_o
);

  localparam int ReportLimit = 10;

  // Decoder state of the prediction
  logic [31:0] code_acc;
  logic [2:0]  bytes_left;
  logic [2:0]  bytes_taken;
  logic        char_open;

  // Code units predicted but not yet seen on the output
  out_t units_due [$];

  // Split a code point into one unit or a surrogate pair
  task automatic push_char(input logic [31:0] cp, input logic [2:0] used);
    logic [31:0] ofs;
    out_t        unit;
    if (cp >= SuppBase) begin
      ofs             = cp - SuppBase;
      unit.code_unit  = HiSurrBase + ofs[25:10];
      unit.last_unit  = 1'b0;
      unit.bytes_used = used;
      units_due.push_back(unit);
      unit.code_unit  = LoSurrBase + {6'd0, ofs[9:0]};
      unit.last_unit  = 1'b1;
      units_due.push_back(unit);
    end else begin
      unit.code_unit  = cp[15:0];
      unit.last_unit  = 1'b1;
      unit.bytes_used = used;
      units_due.push_back(unit);
    end
  endtask

  // Emit the open character and clear the decoder
  task automatic close_char();
    push_char(code_acc, bytes_taken);
    code_acc    = '0;
    bytes_left  = '0;
    bytes_taken = '0;
    char_open   = 1'b0;
  endtask

  // Advance the decoder by one byte
  task automatic decode_byte(input logic [7:0] b, input logic fin);
    int   seq_len;
    int   shift;
    logic run;
    if (char_open) begin
      if (b[7:6] == ContTag) begin
        code_acc    = {code_acc[25:0], b[5:0]};
        bytes_taken = bytes_taken + 3'd1;
        bytes_left  = bytes_left - 3'd1;
        if (bytes_left == 3'd0 || fin) close_char();
        return;
      end
      // a non-continuation byte ends the character early
      close_char();
    end
    if (!b[7]) begin
      push_char({24'd0, b}, 3'd1);
      return;
    end
    // length from the run of ones below bit 6, mask shift capped at 6
    seq_len = 2;
    run     = 1'b1;
    for (int i = 5; i >= 0; i--) begin
      run     = run & b[i];
      seq_len = seq_len + int'(run);
    end
    shift = (seq_len > 6) ? 6 : seq_len;
    if (seq_len > 7) seq_len = 7;
    code_acc    = {24'd0, b & (8'h7F >> shift)};
    bytes_taken = 3'd1;
    bytes_left  = 3'(seq_len - 1);
    char_open   = 1'b1;
    if (fin) close_char();
  endtask

  // Count a failure and report the first few
  task automatic flag_unit(input string what, input out_t want, input out_t got);
    if (fail_cnt_o < ReportLimit) begin
      $display("[%0t] %s: expected unit %h last %b used %0d, got unit %h last %b used %0d",
               $realtime, what, want.code_unit, want.last_unit, want.bytes_used,
               got.code_unit, got.last_unit, got.bytes_used);
    end
    fail_cnt_o++;
  endtask

  // Compare one accepted beat with the oldest unit due
  task automatic check_unit(input out_t got);
    out_t want;
    if (units_due.size() == 0) begin
      flag_unit("unexpected beat", '0, got);
      return;
    end
    want = units_due.pop_front();
    if (got.code_unit !== want.code_unit || got.last_unit !== want.last_unit ||
        got.bytes_used !== want.bytes_used) begin
      flag_unit("mismatch", want, got);
    end
  endtask

  // Take input beats first so a same-cycle result still finds its prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_acc     = '0;
      bytes_left   = '0;
      bytes_taken  = '0;
      char_open    = 1'b0;
      units_due.delete();
      fail_cnt_o   = 0;
      units_due_o  = 0;
      bytes_seen_o = 0;
      units_seen_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        decode_byte(in_data_i.byte_value, in_data_i.is_last);
        bytes_seen_o++;
      end
      if (out_valid_i && !out_stall_i) begin
        check_unit(out_data_i);
        units_seen_o++;
      end
      units_due_o = units_due.size();
    end
  end

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 transcoder testbench
// Feeds directed and random UTF-8 text, well-formed and broken, with random
// idling on both channels; the checker predicts and compares every unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import u8u16_pkg::*;

  localparam int RandomBytes = 140;
  localparam int QuietTail   = 30;
  localparam int DrainCycles = 8;
  localparam int CycleLimit  = 200000;

  logic clk_i;
  logic rst_ni;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  logic idle_en;
  int   stall_left;
  int   cycle_cnt;
  int   bytes_sent;
  int   well_formed_cnt;
  int   broken_cnt;
  int   fail_cnt;
  int   units_due;
  int   bytes_seen;
  int   units_seen;

  utf8_to_utf16_transcoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  utf8_to_utf16_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_cnt_o   (fail_cnt),
    .units_due_o  (units_due),
    .bytes_seen_o (bytes_seen),
    .units_seen_o (units_seen)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Abort a hung run
  initial cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: stall in random bursts while idling is on
  always @(negedge clk_i) begin
    if (!idle_en) begin
      out_stall  = 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  = 1'b1;
      stall_left = $urandom_range(1, 5) - 1;
    end else begin
      out_stall = 1'b0;
    end
  end

  // Drive one byte and hold it until the block takes it
  task automatic send_beat(input logic [7:0] b, input logic fin);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap      = $urandom_range(1, 5);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid           = 1'b1;
    in_data.byte_value = b;
    in_data.is_last    = fin;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  // Hold off the sender until every predicted unit has come out
  task automatic drain_units();
    in_valid = 1'b0;
    while (units_due != 0) @(negedge clk_i);
  endtask

  // Encode a random code point of the given length correctly
  task automatic send_well_formed(input int seq_len, input logic fin);
    logic [31:0] cp;
    logic [7:0]  seq [4];
    case (seq_len)
      1: begin
        cp     = $urandom_range(0, 32'h7F);
        seq[0] = cp[7:0];
      end
      2: begin
        cp     = $urandom_range(32'h80, 32'h7FF);
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {ContTag, cp[5:0]};
      end
      3: begin
        cp     = $urandom_range(32'h800, 32'hFFFF);
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {ContTag, cp[11:6]};
        seq[2] = {ContTag, cp[5:0]};
      end
      default: begin
        cp     = $urandom_range(32'h1_0000, 32'h10_FFFF);
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {ContTag, cp[17:12]};
        seq[2] = {ContTag, cp[11:6]};
        seq[3] = {ContTag, cp[5:0]};
      end
    endcase
    for (int i = 0; i < seq_len; i++) begin
      send_beat(seq[i], fin && (i == seq_len - 1));
    end
    well_formed_cnt++;
  endtask

  // Any lead, stray or invalid, followed by a random number of continuations
  task automatic send_broken();
    int n_cont;
    n_cont = $urandom_range(0, 6);
    send_beat(8'($urandom_range(8'h80, 8'hFF)), $urandom_range(0, 9) == 0);
    for (int i = 0; i < n_cont; i++) begin
      send_beat({ContTag, 6'($urandom)}, $urandom_range(0, 9) == 0);
    end
    broken_cnt++;
  endtask

  initial begin
    int rand_sent;
    int kind;
    logic paused;

    rst_ni          = 1'b0;
    in_valid        = 1'b0;
    in_data         = '0;
    idle_en         = 1'b1;
    bytes_sent      = 0;
    well_formed_cnt = 0;
    broken_cnt      = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // ASCII extremes, the second one flushing as last
    send_beat(8'h00, 1'b0);
    send_beat(8'h7F, 1'b1);
    // Two, three and four byte characters, the last one a surrogate pair
    send_beat(8'hC3, 1'b0);
    send_beat(8'hA9, 1'b0);
    send_beat(8'hE2, 1'b0);
    send_beat(8'h82, 1'b0);
    send_beat(8'hAC, 1'b0);
    send_beat(8'hF0, 1'b0);
    send_beat(8'h9F, 1'b0);
    send_beat(8'h98, 1'b0);
    send_beat(8'h80, 1'b0);
    // Leads 0xFF and 0xFE flushed at once, keeping bit 0
    send_beat(8'hFF, 1'b1);
    send_beat(8'hFE, 1'b1);
    // Stray continuation taken as a lead, then ended early by ASCII
    send_beat(8'h80, 1'b0);
    send_beat(8'h41, 1'b0);
    // Last flag on a continuation before the sequence is full
    send_beat(8'hE0, 1'b0);
    send_beat(8'hA0, 1'b1);
    // Long lead ended early by a new lead that is also last: pair plus unit
    send_beat(8'hFE, 1'b0);
    send_beat(8'hBF, 1'b0);
    send_beat(8'hBF, 1'b0);
    send_beat(8'hBF, 1'b0);
    send_beat(8'hC0, 1'b1);
    // Seven-byte sequence whose accumulator wraps past 32 bits
    send_beat(8'hFF, 1'b0);
    repeat (6) send_beat(8'hBF, 1'b0);
    drain_units();

    // Random text: mostly well-formed characters, some broken runs and noise
    rand_sent = 0;
    paused    = 1'b0;
    while (rand_sent < RandomBytes) begin
      if (!paused && rand_sent >= RandomBytes / 2) begin
        drain_units();
        paused = 1'b1;
      end
      if (rand_sent >= RandomBytes - QuietTail) begin
        idle_en = 1'b0;
      end else if ($urandom_range(0, 15) == 0) begin
        idle_en = ($urandom_range(0, 3) != 0);
      end
      kind = bytes_sent;
      if ($urandom_range(0, 9) < 7) begin
        send_well_formed($urandom_range(1, 4), $urandom_range(0, 6) == 0);
      end else if ($urandom_range(0, 2) != 0) begin
        send_broken();
      end else begin
        send_beat(8'($urandom), $urandom_range(0, 7) == 0);
      end
      rand_sent = rand_sent + (bytes_sent - kind);
    end
    in_valid = 1'b0;

    // Wait for the last units, then watch for strays
    idle_en = 1'b0;
    while (units_due != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Sent %0d bytes (%0d well-formed characters, %0d broken runs); checked %0d units",
             bytes_seen, well_formed_cnt, broken_cnt, units_seen);
    if (fail_cnt == 0 && units_due == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
